>>> rtl/shortest_paths_negative_cycle_marking_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the shortest-path block
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_PATHS_NEGATIVE_CYCLE_MARKING_DEFINES_SVH
`define SHORTEST_PATHS_NEGATIVE_CYCLE_MARKING_DEFINES_SVH

// same-cycle implication
`define SPNC_AST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spnc check failed");

// next-cycle implication
`define SPNC_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spnc check failed");

`endif

>>> rtl/spnc_pkg.sv
// ----------------------------------------------------------------------------
// spnc_pkg
// Shared types and constants of the shortest-path block.
// ----------------------------------------------------------------------------
package spnc_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int COST_BITS    = 48;
  localparam int VID_BITS     = 6;
  localparam int VCNT_BITS    = 7;
  localparam int EIDX_BITS    = 10;
  localparam int ECNT_BITS    = 11;
  localparam int DIST_BITS    = 64;

  localparam logic [1:0] ST_FINITE  = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_NEGCYC  = 2'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  localparam logic CFG_VCOUNT = 1'b0;
  localparam logic CFG_SOURCE = 1'b1;

  typedef struct packed {
    logic [VID_BITS-1:0]  from_v;
    logic [VID_BITS-1:0]  to_v;
    logic [COST_BITS-1:0] cost;
  } edge_t;

  typedef enum logic {
    ALU_ADD,
    ALU_LT
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RFETCH,
    S_RDIST,
    S_RADD,
    S_RCMP,
    S_MFETCH,
    S_MARK,
    S_ORD,
    S_OUT,
    S_DONE
  } state_t;

endpackage

>>> rtl/shortest_paths_negative_cycle_marking.sv
// ----------------------------------------------------------------------------
// shortest_paths_negative_cycle_marking
// Bellman-Ford shortest paths with marking of negative-cycle reach.
//
// An item is taken when start is high and busy is low. A load item
// (action 0) stores one edge; out-of-range endpoints or a full store drop
// the edge and set the drop flag. A run item (action 1) solves over the
// stored edges, then emits one result per vertex in ascending order, each
// on the out_ ports for one cycle with out_valid. Relaxation steps through
// every edge with an edge read, distance read, saturating add and
// compare/write through one shared 65-bit adder; an edge whose source is
// unreached or out of range skips the add and compare/write. Marking reads
// each edge and marks its target when its source is marked. Each result
// takes a distance read and then an output step. busy stays high through
// the run; the receiver cannot stall.
// Reset clears the edge count, drop flag and sets vertex_count 64,
// source_vertex 0. Config writes via cfg_we/cfg_index/cfg_data while idle.
// ----------------------------------------------------------------------------
`include "shortest_paths_negative_cycle_marking_defines.svh"

module shortest_paths_negative_cycle_marking (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_action,
  input  logic [spnc_pkg::VID_BITS-1:0]           in_edge_from,
  input  logic [spnc_pkg::VID_BITS-1:0]           in_edge_to,
  input  logic signed [spnc_pkg::COST_BITS-1:0]   in_edge_cost,
  output logic                                    out_valid,
  output logic [spnc_pkg::VID_BITS-1:0]           out_vertex,
  output logic [1:0]                              out_status,
  output logic signed [spnc_pkg::DIST_BITS-1:0]   out_distance,
  output logic                                    out_edges_dropped,
  output logic                                    out_last,
  input  logic                                    cfg_we,
  input  logic                                    cfg_index,
  input  logic [spnc_pkg::VCNT_BITS-1:0]          cfg_data
);

  localparam int VB = spnc_pkg::VID_BITS;
  localparam int DB = spnc_pkg::DIST_BITS;

  spnc_pkg::state_t state_r, state_nxt;

  logic [spnc_pkg::VCNT_BITS-1:0] vcount_r;
  logic [VB-1:0]                  source_r;
  logic [spnc_pkg::ECNT_BITS-1:0] etotal_r;
  logic                           drop_r;
  logic [spnc_pkg::MAX_VERTICES-1:0] reached_r;
  logic [spnc_pkg::MAX_VERTICES-1:0] marks_r;
  logic [VB-1:0]                  k_r;
  logic [spnc_pkg::EIDX_BITS-1:0] i_r;
  logic [VB-1:0]                  v_r;
  logic signed [DB-1:0]           sum_r;
  logic signed [DB-1:0]           da_r;
  logic signed [DB-1:0]           db_r;
  logic signed [DB-1:0]           dist_mem [spnc_pkg::MAX_VERTICES];

  logic                 out_valid_r;
  logic [VB-1:0]        out_vertex_r;
  logic [1:0]           out_status_r;
  logic signed [DB-1:0] out_distance_r;
  logic                 out_drop_r;
  logic                 out_last_r;

  spnc_pkg::edge_t e_rd, e_wr;
  logic [spnc_pkg::VCNT_BITS-1:0] n;
  logic accept, do_load, load_ok;
  logic last_edge, last_pass, last_vertex, edge_ok, src_ok;
  logic [VB-1:0] rd_a;
  logic dist_we;
  logic [VB-1:0] dist_waddr;
  logic signed [DB-1:0] dist_wdata;
  spnc_pkg::alu_op_t alu_op;
  logic signed [DB-1:0] alu_x, alu_y, alu_sum;
  logic alu_lt;
  logic improve;

  always_comb begin
    n = (vcount_r > spnc_pkg::VCNT_BITS'(spnc_pkg::MAX_VERTICES))
        ? spnc_pkg::VCNT_BITS'(spnc_pkg::MAX_VERTICES) : vcount_r;
  end

  assign accept  = start && !busy;
  assign do_load = accept && (in_action == spnc_pkg::ACT_LOAD);
  assign load_ok = (etotal_r < spnc_pkg::ECNT_BITS'(spnc_pkg::MAX_EDGES))
                   && ({1'b0, in_edge_from} < n) && ({1'b0, in_edge_to} < n);
  assign e_wr    = '{from_v: in_edge_from, to_v: in_edge_to, cost: in_edge_cost};

  spnc_edge_ram u_edges (
    .clk   (clk),
    .we    (do_load && load_ok),
    .waddr (etotal_r[spnc_pkg::EIDX_BITS-1:0]),
    .wdata (e_wr),
    .raddr (i_r),
    .rdata (e_rd)
  );

  assign last_edge   = ({1'b0, i_r} + 1'b1) == etotal_r;
  assign last_pass   = ({1'b0, k_r} + 1'b1) == n;
  assign last_vertex = ({1'b0, v_r} + 1'b1) == n;
  assign src_ok      = {1'b0, source_r} < n;
  assign edge_ok     = ({1'b0, e_rd.from_v} < n) && ({1'b0, e_rd.to_v} < n);

  // shared adder: add cost in S_RADD, compare sum against old distance in S_RCMP
  always_comb begin
    if (state_r == spnc_pkg::S_RCMP) begin
      alu_op = spnc_pkg::ALU_LT;
      alu_x  = sum_r;
      alu_y  = db_r;
    end else begin
      alu_op = spnc_pkg::ALU_ADD;
      alu_x  = da_r;
      alu_y  = DB'(signed'(e_rd.cost));
    end
  end

  spnc_alu u_alu (
    .op  (alu_op),
    .x   (alu_x),
    .y   (alu_y),
    .sum (alu_sum),
    .lt  (alu_lt)
  );

  assign improve = !reached_r[e_rd.to_v] || alu_lt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spnc_pkg::S_IDLE: begin
        if (accept && in_action == spnc_pkg::ACT_RUN) state_nxt = spnc_pkg::S_INIT;
      end
      spnc_pkg::S_INIT: begin
        if (n == '0) state_nxt = spnc_pkg::S_DONE;
        else if (etotal_r == '0) state_nxt = spnc_pkg::S_ORD;
        else state_nxt = spnc_pkg::S_RFETCH;
      end
      spnc_pkg::S_RFETCH: state_nxt = spnc_pkg::S_RDIST;
      spnc_pkg::S_RDIST: begin
        if (edge_ok && reached_r[e_rd.from_v]) state_nxt = spnc_pkg::S_RADD;
        else if (last_edge && last_pass) state_nxt = spnc_pkg::S_MFETCH;
        else state_nxt = spnc_pkg::S_RFETCH;
      end
      spnc_pkg::S_RADD: state_nxt = spnc_pkg::S_RCMP;
      spnc_pkg::S_RCMP: begin
        if (last_edge && last_pass) state_nxt = spnc_pkg::S_MFETCH;
        else state_nxt = spnc_pkg::S_RFETCH;
      end
      spnc_pkg::S_MFETCH: state_nxt = spnc_pkg::S_MARK;
      spnc_pkg::S_MARK: begin
        if (last_edge && last_pass) state_nxt = spnc_pkg::S_ORD;
        else state_nxt = spnc_pkg::S_MFETCH;
      end
      spnc_pkg::S_ORD: state_nxt = spnc_pkg::S_OUT;
      spnc_pkg::S_OUT: begin
        if (last_vertex) state_nxt = spnc_pkg::S_DONE;
        else state_nxt = spnc_pkg::S_ORD;
      end
      spnc_pkg::S_DONE: state_nxt = spnc_pkg::S_IDLE;
      default: state_nxt = spnc_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy       = (state_r != spnc_pkg::S_IDLE);
    rd_a       = (state_r == spnc_pkg::S_ORD) ? v_r : e_rd.from_v;
    dist_we    = 1'b0;
    dist_waddr = e_rd.to_v;
    dist_wdata = sum_r;
    if (state_r == spnc_pkg::S_INIT) begin
      dist_we    = src_ok;
      dist_waddr = source_r;
      dist_wdata = '0;
    end else if (state_r == spnc_pkg::S_RCMP) begin
      dist_we    = improve;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[dist_waddr] <= dist_wdata;
    end
    da_r <= dist_mem[rd_a];
    db_r <= dist_mem[e_rd.to_v];
    if (state_r == spnc_pkg::S_RADD) begin
      sum_r <= alu_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spnc_pkg::S_IDLE;
      vcount_r    <= spnc_pkg::VCNT_BITS'(spnc_pkg::MAX_VERTICES);
      source_r    <= '0;
      etotal_r    <= '0;
      drop_r      <= 1'b0;
      reached_r   <= '0;
      marks_r     <= '0;
      k_r         <= '0;
      i_r         <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == spnc_pkg::S_OUT);
      if (cfg_we) begin
        if (cfg_index == spnc_pkg::CFG_VCOUNT) vcount_r <= cfg_data;
        else source_r <= cfg_data[VB-1:0];
      end
      if (do_load) begin
        if (load_ok) etotal_r <= etotal_r + 1'b1;
        else drop_r <= 1'b1;
      end
      unique case (state_r)
        spnc_pkg::S_INIT: begin
          reached_r <= src_ok ? (spnc_pkg::MAX_VERTICES'(1) << source_r) : '0;
          marks_r   <= '0;
          k_r <= '0;
          i_r <= '0;
          v_r <= '0;
        end
        spnc_pkg::S_RCMP, spnc_pkg::S_RDIST, spnc_pkg::S_MARK: begin
          if (state_r == spnc_pkg::S_RCMP && improve) begin
            reached_r[e_rd.to_v] <= 1'b1;
            if (last_pass) marks_r[e_rd.to_v] <= 1'b1;
          end
          if (state_r == spnc_pkg::S_MARK && edge_ok && marks_r[e_rd.from_v]) begin
            marks_r[e_rd.to_v] <= 1'b1;
          end
          // step to the next edge unless S_RDIST hands the edge to the adder
          if (state_r != spnc_pkg::S_RDIST || state_nxt != spnc_pkg::S_RADD) begin
            if (last_edge) begin
              i_r <= '0;
              k_r <= last_pass ? '0 : k_r + 1'b1;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        spnc_pkg::S_OUT: begin
          out_vertex_r   <= v_r;
          out_drop_r     <= drop_r;
          out_last_r     <= last_vertex;
          out_distance_r <= (!marks_r[v_r] && reached_r[v_r]) ? da_r : '0;
          if (marks_r[v_r]) out_status_r <= spnc_pkg::ST_NEGCYC;
          else if (!reached_r[v_r]) out_status_r <= spnc_pkg::ST_UNREACH;
          else out_status_r <= spnc_pkg::ST_FINITE;
          v_r <= v_r + 1'b1;
        end
        spnc_pkg::S_DONE: begin
          etotal_r <= '0;
          drop_r   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_vertex        = out_vertex_r;
  assign out_status        = out_status_r;
  assign out_distance      = out_distance_r;
  assign out_edges_dropped = out_drop_r;
  assign out_last          = out_last_r;

  `SPNC_AST_NXT(a_out_strobe, state_r == spnc_pkg::S_OUT, out_valid)
  `SPNC_AST(a_dist_zero, out_valid && out_status != spnc_pkg::ST_FINITE, out_distance == '0)
  `SPNC_AST(a_relax_src, state_r == spnc_pkg::S_RCMP, reached_r[e_rd.from_v])
  `SPNC_AST_NXT(a_run_start, accept && in_action == spnc_pkg::ACT_RUN,
                state_r == spnc_pkg::S_INIT)

endmodule

>>> rtl/spnc_edge_ram.sv
// ----------------------------------------------------------------------------
// spnc_edge_ram
// Edge store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spnc_edge_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [spnc_pkg::EIDX_BITS-1:0]   waddr,
  input  spnc_pkg::edge_t                  wdata,
  input  logic [spnc_pkg::EIDX_BITS-1:0]   raddr,
  output spnc_pkg::edge_t                  rdata
);

  spnc_pkg::edge_t mem [spnc_pkg::MAX_EDGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/spnc_alu.sv
// ----------------------------------------------------------------------------
// spnc_alu
// Shared 65-bit adder: saturating add of an edge cost, or signed less-than.
// ----------------------------------------------------------------------------
module spnc_alu (
  input  spnc_pkg::alu_op_t                     op,
  input  logic signed [spnc_pkg::DIST_BITS-1:0] x,
  input  logic signed [spnc_pkg::DIST_BITS-1:0] y,
  output logic signed [spnc_pkg::DIST_BITS-1:0] sum,
  output logic                                  lt
);

  logic [spnc_pkg::DIST_BITS:0] xe;
  logic [spnc_pkg::DIST_BITS:0] ye;
  logic [spnc_pkg::DIST_BITS:0] s;
  logic                         cin;

  always_comb begin
    xe  = {x[spnc_pkg::DIST_BITS-1], x};
    cin = (op == spnc_pkg::ALU_LT);
    ye  = cin ? ~{y[spnc_pkg::DIST_BITS-1], y} : {y[spnc_pkg::DIST_BITS-1], y};
    s   = xe + ye + {{spnc_pkg::DIST_BITS{1'b0}}, cin};
    lt  = s[spnc_pkg::DIST_BITS];
    // overflow when the two top bits disagree: clamp to the bound
    if (s[spnc_pkg::DIST_BITS] != s[spnc_pkg::DIST_BITS-1]) begin
      sum = s[spnc_pkg::DIST_BITS] ? {1'b1, {(spnc_pkg::DIST_BITS-1){1'b0}}}
                                   : {1'b0, {(spnc_pkg::DIST_BITS-1){1'b1}}};
    end else begin
      sum = s[spnc_pkg::DIST_BITS-1:0];
    end
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Shortest-path block testbench
// Loads edge items, runs solves under several vertex counts and sources, and
// checks every per-vertex result against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DIST_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint DIST_MIN = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [spnc_pkg::VID_BITS-1:0] vertex;
    logic [1:0]                    status;
    longint                        distance;
    logic                          dropped;
    logic                          last;
  } vres_t;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  start;
  logic                                  busy;
  logic                                  in_action;
  logic [spnc_pkg::VID_BITS-1:0]         in_edge_from;
  logic [spnc_pkg::VID_BITS-1:0]         in_edge_to;
  logic signed [spnc_pkg::COST_BITS-1:0] in_edge_cost;
  logic                                  out_valid;
  logic [spnc_pkg::VID_BITS-1:0]         out_vertex;
  logic [1:0]                            out_status;
  logic signed [spnc_pkg::DIST_BITS-1:0] out_distance;
  logic                                  out_edges_dropped;
  logic                                  out_last;
  logic                                  cfg_we;
  logic                                  cfg_index;
  logic [spnc_pkg::VCNT_BITS-1:0]        cfg_data;

  // predictor state
  logic [spnc_pkg::VCNT_BITS-1:0] vcount_reg;
  logic [spnc_pkg::VID_BITS-1:0]  source_reg;
  logic [spnc_pkg::VID_BITS-1:0]  arc_from [spnc_pkg::MAX_EDGES];
  logic [spnc_pkg::VID_BITS-1:0]  arc_to   [spnc_pkg::MAX_EDGES];
  longint                         arc_cost [spnc_pkg::MAX_EDGES];
  int                             arc_total;
  logic                           drop_seen;
  longint                         dist_tab [spnc_pkg::MAX_VERTICES];
  logic                           reached  [spnc_pkg::MAX_VERTICES];
  logic                           marked   [spnc_pkg::MAX_VERTICES];

  vres_t vertex_results_q[$];
  int    errors;
  int    items_sent;
  int    runs_done;
  int    results_seen;

  shortest_paths_negative_cycle_marking i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_edge_from(in_edge_from), .in_edge_to(in_edge_to),
    .in_edge_cost(in_edge_cost), .out_valid(out_valid), .out_vertex(out_vertex),
    .out_status(out_status), .out_distance(out_distance),
    .out_edges_dropped(out_edges_dropped), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("shortest_paths_negative_cycle_marking test failed");
    $finish;
  end

  function automatic int live_n();
    return (vcount_reg > spnc_pkg::MAX_VERTICES) ? spnc_pkg::MAX_VERTICES
                                                 : int'(vcount_reg);
  endfunction

  function automatic longint sat_sum(longint a, longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 + DIST_MAX) return DIST_MAX;
    if (s < 65'sd0 + DIST_MIN) return DIST_MIN;
    return s[63:0];
  endfunction

  function automatic void store_edge(logic [spnc_pkg::VID_BITS-1:0] a,
                                     logic [spnc_pkg::VID_BITS-1:0] b,
                                     logic [spnc_pkg::COST_BITS-1:0] c);
    int n;
    n = live_n();
    if (arc_total >= spnc_pkg::MAX_EDGES || a >= n || b >= n) begin
      drop_seen = 1'b1;
    end else begin
      arc_from[arc_total] = a;
      arc_to[arc_total]   = b;
      arc_cost[arc_total] = {{(64-spnc_pkg::COST_BITS){c[spnc_pkg::COST_BITS-1]}}, c};
      arc_total++;
    end
  endfunction

  function automatic void solve_paths();
    int n;
    int a;
    int b;
    longint s;
    vres_t r;
    n = live_n();
    for (int v = 0; v < spnc_pkg::MAX_VERTICES; v++) begin
      reached[v] = 1'b0;
      marked[v]  = 1'b0;
    end
    if (source_reg < n) begin
      dist_tab[source_reg] = 0;
      reached[source_reg]  = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < arc_total; i++) begin
        a = arc_from[i];
        b = arc_to[i];
        if (a >= n || b >= n || !reached[a]) continue;
        s = sat_sum(dist_tab[a], arc_cost[i]);
        if (!reached[b] || s < dist_tab[b]) begin
          dist_tab[b] = s;
          reached[b]  = 1'b1;
          if (k == n - 1) marked[b] = 1'b1;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < arc_total; i++) begin
        a = arc_from[i];
        b = arc_to[i];
        if (a < n && b < n && marked[a]) marked[b] = 1'b1;
      end
    end
    for (int v = 0; v < n; v++) begin
      r.vertex   = v[spnc_pkg::VID_BITS-1:0];
      r.distance = 0;
      if (marked[v]) r.status = spnc_pkg::ST_NEGCYC;
      else if (!reached[v]) r.status = spnc_pkg::ST_UNREACH;
      else begin
        r.status   = spnc_pkg::ST_FINITE;
        r.distance = dist_tab[v];
      end
      r.dropped = drop_seen;
      r.last    = (v == n - 1);
      vertex_results_q = {vertex_results_q, r};
    end
    arc_total = 0;
    drop_seen = 1'b0;
    runs_done++;
  endfunction

  // result checker
  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (vertex_results_q.size() == 0) begin
        $display("%0t: unexpected result vertex %0d", $time, out_vertex);
        errors++;
      end else begin
        e = vertex_results_q.pop_front();
        if (out_vertex !== e.vertex) begin
          $display("%0t: vertex exp %0d got %0d", $time, e.vertex, out_vertex);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status v%0d exp %0d got %0d", $time, e.vertex, e.status,
                   out_status);
          errors++;
        end
        if (out_distance !== e.distance) begin
          $display("%0t: distance v%0d exp %0d got %0d", $time, e.vertex, e.distance,
                   out_distance);
          errors++;
        end
        if (out_edges_dropped !== e.dropped) begin
          $display("%0t: edges_dropped v%0d exp %0b got %0b", $time, e.vertex,
                   e.dropped, out_edges_dropped);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last v%0d exp %0b got %0b", $time, e.vertex, e.last, out_last);
          errors++;
        end
      end
    end
  end

  // called at a rising edge; returns at the edge that took the item, or after the idle gap that follows it
  task automatic send_item(logic act, logic [spnc_pkg::VID_BITS-1:0] a,
                           logic [spnc_pkg::VID_BITS-1:0] b,
                           logic [spnc_pkg::COST_BITS-1:0] c, int gap);
    logic was_busy;
    start        <= 1'b1;
    in_action    <= act;
    in_edge_from <= a;
    in_edge_to   <= b;
    in_edge_cost <= c;
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    items_sent++;
    if (act == spnc_pkg::ACT_LOAD) store_edge(a, b, c);
    else solve_paths();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_edge(int a, int b, longint c);
    send_item(spnc_pkg::ACT_LOAD, a[spnc_pkg::VID_BITS-1:0], b[spnc_pkg::VID_BITS-1:0],
              c[spnc_pkg::COST_BITS-1:0], $urandom_range(0, 19));
  endtask

  task automatic run_solve();
    send_item(spnc_pkg::ACT_RUN, '0, '0, '0, $urandom_range(0, 19));
  endtask

  // drain all results, let a run with no results finish, then settle
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (vertex_results_q.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, int value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[spnc_pkg::VCNT_BITS-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == spnc_pkg::CFG_VCOUNT) vcount_reg = value[spnc_pkg::VCNT_BITS-1:0];
    else source_reg = value[spnc_pkg::VID_BITS-1:0];
  endtask

  function automatic longint rand_cost();
    case ($urandom_range(0, 9))
      0: return longint'({$urandom, $urandom}) >>> 16;
      1: return $urandom_range(0, 1) ? -(64'sd1 <<< 47) : (64'sd1 <<< 47) - 1;
      2: return -longint'($urandom_range(0, 30));
      default: return longint'($urandom_range(0, 60)) - 15;
    endcase
  endfunction

  // extremes of cost and endpoints, out-of-range drop, unreached source edges
  task automatic test_basic();
    write_cfg(spnc_pkg::CFG_VCOUNT, 5);
    write_cfg(spnc_pkg::CFG_SOURCE, 0);
    load_edge(0, 1, (64'sd1 <<< 47) - 1);
    load_edge(0, 2, -(64'sd1 <<< 47));
    load_edge(2, 3, 5);
    load_edge(1, 3, -7);
    load_edge(63, 0, 1);
    load_edge(4, 0, 2);
    run_solve();
    load_edge(0, 4, 3);
    run_solve();
  endtask

  task automatic test_negative_cycle();
    write_cfg(spnc_pkg::CFG_VCOUNT, 6);
    write_cfg(spnc_pkg::CFG_SOURCE, 1);
    load_edge(1, 2, 4);
    load_edge(2, 3, -3);
    load_edge(3, 2, -2);
    load_edge(3, 4, 1);
    load_edge(0, 5, 1);
    run_solve();
  endtask

  task automatic test_source_out_of_range();
    write_cfg(spnc_pkg::CFG_VCOUNT, 3);
    write_cfg(spnc_pkg::CFG_SOURCE, 63);
    load_edge(0, 1, 1);
    run_solve();
  endtask

  task automatic test_count_extremes();
    write_cfg(spnc_pkg::CFG_VCOUNT, 0);
    load_edge(0, 0, 1);
    run_solve();
    write_cfg(spnc_pkg::CFG_VCOUNT, 127);
    write_cfg(spnc_pkg::CFG_SOURCE, 63);
    load_edge(63, 0, -1);
    load_edge(0, 62, 2);
    run_solve();
    write_cfg(spnc_pkg::CFG_VCOUNT, 1);
    write_cfg(spnc_pkg::CFG_SOURCE, 0);
    load_edge(0, 0, -1);
    run_solve();
  endtask

  task automatic test_count_lowered();
    write_cfg(spnc_pkg::CFG_VCOUNT, 8);
    write_cfg(spnc_pkg::CFG_SOURCE, 0);
    load_edge(0, 7, 1);
    load_edge(7, 1, 1);
    load_edge(0, 2, 3);
    write_cfg(spnc_pkg::CFG_VCOUNT, 4);
    run_solve();
  endtask

  task automatic test_random_graphs(int target);
    int n;
    int ecount;
    while (items_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1: n = $urandom_range(9, 63);
        2:    n = 64;
        default: n = $urandom_range(1, 8);
      endcase
      write_cfg(spnc_pkg::CFG_VCOUNT, n);
      write_cfg(spnc_pkg::CFG_SOURCE, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                                  : $urandom_range(0, n - 1));
      ecount = (n > 16) ? $urandom_range(0, 10) : $urandom_range(0, 14);
      for (int i = 0; i < ecount; i++) begin
        if ($urandom_range(0, 9) == 0)
          load_edge($urandom_range(0, 63), $urandom_range(0, 63), rand_cost());
        else
          load_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_cost());
      end
      // stretch without sender gaps
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 4; i++)
          send_item(spnc_pkg::ACT_LOAD, 6'($urandom_range(0, n - 1)),
                    6'($urandom_range(0, n - 1)),
                    spnc_pkg::COST_BITS'(rand_cost()), 0);
      end
      run_solve();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_action    = spnc_pkg::ACT_LOAD;
    in_edge_from = '0;
    in_edge_to   = '0;
    in_edge_cost = '0;
    cfg_we       = 1'b0;
    cfg_index    = spnc_pkg::CFG_VCOUNT;
    cfg_data     = '0;
    vcount_reg   = 7'd64;
    source_reg   = '0;
    arc_total    = 0;
    drop_seen    = 1'b0;
    errors       = 0;
    items_sent   = 0;
    runs_done    = 0;
    results_seen = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic();
    test_negative_cycle();
    test_source_out_of_range();
    test_count_extremes();
    test_count_lowered();
    test_random_graphs(230);
    wait_idle();
    $display("Covered %0d items in %0d solves, %0d vertex results checked,",
             items_sent, runs_done, results_seen);
    $display("including negative cycles, dropped edges and vertex count extremes.");
    if (errors == 0) begin
      $display("shortest_paths_negative_cycle_marking test passed");
    end else begin
      $display("shortest_paths_negative_cycle_marking test failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/spnc_pkg.sv
rtl/spnc_edge_ram.sv
rtl/spnc_alu.sv
rtl/shortest_paths_negative_cycle_marking.sv
verif/tb_top.sv
